### hw/rtl/cbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types, constants and helpers for the column block statistics block.
// ----------------------------------------------------------------------------
package cbs_pkg;

   localparam int unsigned ROW_W = 15;
   localparam logic [ROW_W-1:0] MAX_ROWS = 15'd32767;

   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 240;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 64;

   // Register indexes (paddr[3] with 8-byte spacing)
   localparam logic REG_ELEMENT_TYPE  = 1'b0;
   localparam logic REG_NULL_SENTINEL = 1'b1;

   typedef enum logic [2:0] {
      ELEM_S8  = 3'd0,
      ELEM_U8  = 3'd1,
      ELEM_S16 = 3'd2,
      ELEM_U16 = 3'd3,
      ELEM_S32 = 3'd4,
      ELEM_U32 = 3'd5,
      ELEM_S64 = 3'd6,
      ELEM_U64 = 3'd7
   } elem_type_type;

   // Element size selector: element_type[2:1]
   localparam logic [1:0] SIZE_8  = 2'd0;
   localparam logic [1:0] SIZE_16 = 2'd1;
   localparam logic [1:0] SIZE_32 = 2'd2;
   localparam logic [1:0] SIZE_64 = 2'd3;

   localparam logic [63:0] POS_LIMIT_64 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_LIMIT_64 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ALL_ONES_64  = 64'hFFFF_FFFF_FFFF_FFFF;

   function automatic logic type_signed(input logic [2:0] etype);
      return (etype[0] == 1'b0);
   endfunction

   function automatic logic [63:0] width_mask(input logic [2:0] etype);
      logic [63:0] mask;
      unique case (etype[2:1])
         SIZE_8:  mask = 64'h0000_0000_0000_00FF;
         SIZE_16: mask = 64'h0000_0000_0000_FFFF;
         SIZE_32: mask = 64'h0000_0000_FFFF_FFFF;
         SIZE_64: mask = ALL_ONES_64;
         default: mask = ALL_ONES_64;
      endcase
      return mask;
   endfunction

   // Sign or zero extend the low bits of raw to 64 bits.
   function automatic logic [63:0] extend_value(input logic [63:0] raw,
                                                input logic [2:0]  etype);
      logic [63:0] value;
      logic        sgn;
      sgn = type_signed(etype);
      unique case (etype[2:1])
         SIZE_8:  value = {{56{sgn & raw[7]}},  raw[7:0]};
         SIZE_16: value = {{48{sgn & raw[15]}}, raw[15:0]};
         SIZE_32: value = {{32{sgn & raw[31]}}, raw[31:0]};
         SIZE_64: value = raw;
         default: value = raw;
      endcase
      return value;
   endfunction

   function automatic logic less_than(input logic [63:0] a, input logic [63:0] b,
                                      input logic sgn);
      return sgn ? ((a ^ NEG_LIMIT_64) < (b ^ NEG_LIMIT_64)) : (a < b);
   endfunction

   function automatic logic [63:0] least_start(input logic [2:0] etype);
      return type_signed(etype) ? POS_LIMIT_64 : ALL_ONES_64;
   endfunction

   function automatic logic [63:0] greatest_start(input logic [2:0] etype);
      return type_signed(etype) ? NEG_LIMIT_64 : 64'd0;
   endfunction

endpackage

### hw/rtl/column_block_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_block_statistics
// Running min, max, wrapping sum and null count over a block of column
// values, with the first row of each extreme, one result per block.
// ----------------------------------------------------------------------------
// Channel   Dir   Kind          Contents
// req_*     in    stream        tdata: element_bits; tlast: block_end
// rsp_*     out   stream        tdata: statistics of one block
// csr_*     in    APB slave     0x0 element_type, 0x8 null_sentinel
//
// One item per cycle, but an end-of-block item waits on a full result
// register; other items pass it freely. rsp_tvalid rises once the end item
// has passed the input register, then one add and two 64-bit compares into
// the state and the result register.
// Reset is synchronous and restores type s8, sentinel 0 and a clear block.
// ----------------------------------------------------------------------------
module column_block_statistics (
   input  logic                              clock,
   input  logic                              reset,
   // element_bits[63:0]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cbs_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tlast,
   // minimum_bits[63:0], maximum_bits[127:64], total_bits[191:128],
   // minimum_row[206:192], maximum_row[221:207], null_rows[236:222],
   // row_overflow[237], zero[239:238]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cbs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cbs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [cbs_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [cbs_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int unsigned RW = cbs_pkg::ROW_W;

   // configuration
   logic [2:0]  element_type_ff;
   logic [63:0] null_sentinel_ff;

   // input register
   logic        in_valid_ff;
   logic [63:0] in_bits_ff;
   logic        in_last_ff;

   // block state
   logic [63:0]   total_ff,    total_in;
   logic [63:0]   least_ff,    least_in;
   logic [63:0]   greatest_ff, greatest_in;
   logic [RW-1:0] least_row_ff,    least_row_in;
   logic [RW-1:0] greatest_row_ff, greatest_row_in;
   logic [RW-1:0] null_tally_ff,   null_tally_in;
   logic [RW-1:0] row_position_ff, row_position_in;
   logic          overflow_ff,     overflow_in;

   // result register
   logic                         rsp_valid_ff;
   logic [cbs_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic        csr_write;
   logic        type_write;
   logic        sentinel_write;
   logic        out_free;
   logic        advance;
   logic        is_signed;
   logic [63:0] mask;
   logic        is_null;
   logic [63:0] value;
   logic        past_limit;

   assign csr_pready     = 1'b1;
   assign csr_write      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign type_write     = csr_write && (csr_paddr[3] == cbs_pkg::REG_ELEMENT_TYPE);
   assign sentinel_write = csr_write && (csr_paddr[3] == cbs_pkg::REG_NULL_SENTINEL);

   assign csr_prdata = (csr_paddr[3] == cbs_pkg::REG_NULL_SENTINEL) ? null_sentinel_ff
                                                                   : {61'd0, element_type_ff};

   // An end item needs the result slot; any other item always drains.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign is_signed  = cbs_pkg::type_signed(element_type_ff);
   assign mask       = cbs_pkg::width_mask(element_type_ff);
   assign is_null    = ((in_bits_ff ^ null_sentinel_ff) & mask) == 64'd0;
   assign value      = cbs_pkg::extend_value(in_bits_ff, element_type_ff);
   assign past_limit = (row_position_ff >= cbs_pkg::MAX_ROWS);

   always_comb begin
      total_in        = total_ff;
      least_in        = least_ff;
      greatest_in     = greatest_ff;
      least_row_in    = least_row_ff;
      greatest_row_in = greatest_row_ff;
      null_tally_in   = null_tally_ff;
      row_position_in = row_position_ff;
      overflow_in     = overflow_ff;
      if (past_limit) begin
         overflow_in     = 1'b1;
         row_position_in = cbs_pkg::MAX_ROWS;
      end else begin
         if (is_null) begin
            null_tally_in = null_tally_ff + RW'(1);
         end else begin
            total_in = total_ff + value;
            if (cbs_pkg::less_than(value, least_ff, is_signed)) begin
               least_in     = value;
               least_row_in = row_position_ff;
            end
            if (cbs_pkg::less_than(greatest_ff, value, is_signed)) begin
               greatest_in     = value;
               greatest_row_in = row_position_ff;
            end
         end
         row_position_in = row_position_ff + RW'(1);
      end
   end

   // control and block state
   always_ff @(posedge clock) begin
      if (reset) begin
         element_type_ff  <= cbs_pkg::ELEM_S8;
         null_sentinel_ff <= 64'd0;
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         total_ff         <= 64'd0;
         least_ff         <= cbs_pkg::least_start(cbs_pkg::ELEM_S8);
         greatest_ff      <= cbs_pkg::greatest_start(cbs_pkg::ELEM_S8);
         least_row_ff     <= '0;
         greatest_row_ff  <= '0;
         null_tally_ff    <= '0;
         row_position_ff  <= '0;
         overflow_ff      <= 1'b0;
      end else begin
         if (sentinel_write) begin
            null_sentinel_ff <= csr_pwdata;
         end

         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end

         if (advance && in_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (type_write) begin
            // new type drops any partial block
            element_type_ff <= csr_pwdata[2:0];
            total_ff        <= 64'd0;
            least_ff        <= cbs_pkg::least_start(csr_pwdata[2:0]);
            greatest_ff     <= cbs_pkg::greatest_start(csr_pwdata[2:0]);
            least_row_ff    <= '0;
            greatest_row_ff <= '0;
            null_tally_ff   <= '0;
            row_position_ff <= '0;
            overflow_ff     <= 1'b0;
         end else if (advance) begin
            if (in_last_ff) begin
               total_ff        <= 64'd0;
               least_ff        <= cbs_pkg::least_start(element_type_ff);
               greatest_ff     <= cbs_pkg::greatest_start(element_type_ff);
               least_row_ff    <= '0;
               greatest_row_ff <= '0;
               null_tally_ff   <= '0;
               row_position_ff <= '0;
               overflow_ff     <= 1'b0;
            end else begin
               total_ff        <= total_in;
               least_ff        <= least_in;
               greatest_ff     <= greatest_in;
               least_row_ff    <= least_row_in;
               greatest_row_ff <= greatest_row_in;
               null_tally_ff   <= null_tally_in;
               row_position_ff <= row_position_in;
               overflow_ff     <= overflow_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_bits_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         rsp_data_ff <= {2'b00, overflow_in, null_tally_in, greatest_row_in, least_row_in,
                         total_in, greatest_in, least_in};
      end
   end

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> rsp_valid_ff)
      else $error("end of block did not produce a result");

   a_end_clears_block: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff && !type_write) |=>
         (row_position_ff == '0 && null_tally_ff == '0 && !overflow_ff))
      else $error("block state not cleared after result");

   a_overflow_saturates: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (row_position_ff == cbs_pkg::MAX_ROWS))
      else $error("overflow flagged below the row limit");

   a_extreme_rows_seen: assert property (@(posedge clock) disable iff (reset)
      (least_row_ff <= row_position_ff) && (greatest_row_ff <= row_position_ff))
      else $error("extreme row beyond current row position");

   a_stage_never_lost: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("stalled input item dropped");

endmodule
